>>> hw/rtl/sph_dp_pkg.sv
// Shared types and constants for the SPH density and pressure block.
// No dependencies; imported by every module of the block.
package sph_dp_pkg;

    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_SQ     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DENSITY_SCALE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REST_DENSITY  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STIFFNESS     = 2'd3;

    localparam logic [31:0] RADIUS_SQ_RST     = 32'h0001_0000;
    localparam logic [31:0] DENSITY_SCALE_RST = 32'h0001_0000;
    localparam logic [31:0] REST_DENSITY_RST  = 32'h0000_0000;
    localparam logic [31:0] STIFFNESS_RST     = 32'h0001_0000;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    localparam logic [47:0] OUT_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] PRS_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] PRS_NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [31:0] radius_sq;
        logic [31:0] density_scale;
        logic [31:0] rest_density;
        logic [31:0] stiffness;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic        last;
        logic        hit;
        logic [31:0] d;
    } t_front_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D2,
        ST_D3,
        ST_D3S,
        ST_T,
        ST_TERM,
        ST_ACC,
        ST_PD,
        ST_PM,
        ST_PS
    } t_back_state;

endpackage

>>> hw/rtl/sph_dp_front.sv
// Front end: accepts items, holds the target and forms the radius test.
// Depends on sph_dp_pkg.
module sph_dp_front import sph_dp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_op,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_last,
    input  logic [31:0]        i_radius_sq,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_front_item        o_q_item
);

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        r_op1, r_op2, r_op3, r_op4;
    logic        r_last1, r_last2, r_last3, r_last4;
    logic [31:0] r_tx, r_ty, r_tz;
    logic [32:0] r_dx, r_dy, r_dz;
    logic [31:0] r_ax, r_ay, r_az;
    logic [63:0] r_sx, r_sy, r_sz;
    logic [49:0] r_r2;

    logic        w_en;
    logic        w_acc;
    logic [32:0] w_nx, w_ny, w_nz;
    logic [65:0] w_sq_sum;

    assign w_en   = !r_v4 || !i_q_full;
    assign w_acc  = i_push && w_en;
    assign o_full = !w_en;

    assign w_nx = (~r_dx) + 33'd1;
    assign w_ny = (~r_dy) + 33'd1;
    assign w_nz = (~r_dz) + 33'd1;

    assign w_sq_sum = {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};

    assign o_q_push      = r_v4 && !i_q_full;
    assign o_q_item.op   = r_op4;
    assign o_q_item.last = r_last4;
    assign o_q_item.hit  = r_r2 < {18'd0, i_radius_sq};
    assign o_q_item.d    = i_radius_sq - r_r2[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_tx <= '0;
            r_ty <= '0;
            r_tz <= '0;
        end else begin
            if (w_en) begin
                r_v1 <= w_acc;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
            if (w_acc && i_op == OP_LOAD) begin
                r_tx <= i_pos_x;
                r_ty <= i_pos_y;
                r_tz <= i_pos_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1   <= i_op;
            r_last1 <= i_last;
            r_dx    <= {i_pos_x[31], i_pos_x} - {r_tx[31], r_tx};
            r_dy    <= {i_pos_y[31], i_pos_y} - {r_ty[31], r_ty};
            r_dz    <= {i_pos_z[31], i_pos_z} - {r_tz[31], r_tz};

            r_op2   <= r_op1;
            r_last2 <= r_last1;
            r_ax    <= r_dx[32] ? w_nx[31:0] : r_dx[31:0];
            r_ay    <= r_dy[32] ? w_ny[31:0] : r_dy[31:0];
            r_az    <= r_dz[32] ? w_nz[31:0] : r_dz[31:0];

            r_op3   <= r_op2;
            r_last3 <= r_last2;
            r_sx    <= r_ax * r_ax;
            r_sy    <= r_ay * r_ay;
            r_sz    <= r_az * r_az;

            r_op4   <= r_op3;
            r_last4 <= r_last3;
            r_r2    <= w_sq_sum[65:16];
        end
    end

endmodule

>>> hw/rtl/sph_dp_queue.sv
// Short queue between front and back end.
// Depends on sph_dp_pkg.
module sph_dp_queue import sph_dp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output t_front_item o_item
);

    t_front_item       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = r_cnt == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/sph_dp_back.sv
// Back end: poly6 term, saturating accumulate, pressure and result register.
// Depends on sph_dp_pkg.
module sph_dp_back import sph_dp_pkg::*; #(
    parameter int unsigned ACC_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_front_item        i_q_item,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [47:0]        o_density,
    output logic signed [47:0] o_pressure
);

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    t_back_state          r_state, n_state;
    logic [ACC_WIDTH-1:0] r_sum, n_sum;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_d;
    logic                 r_last;
    logic [63:0]          r_p0, r_p1;
    logic [63:0]          r_x;
    logic [ACC_WIDTH-1:0] r_term;
    logic                 r_neg;
    logic [47:0]          r_density;
    logic [47:0]          r_pressure;

    logic                 w_mul_en;
    logic                 w_load;
    logic [31:0]          w_a0, w_a1, w_b;
    logic [79:0]          w_psum;
    logic [ACC_WIDTH-1:0] w_term;
    logic [ACC_WIDTH:0]   w_acc_sum;
    logic [63:0]          w_sum64;
    logic [47:0]          w_dens;
    logic [47:0]          w_rest48;
    logic                 w_ge;
    logic [47:0]          w_mag;
    logic [47:0]          w_cap;
    logic [47:0]          w_mag_sat;
    logic [47:0]          w_prs;

    assign w_psum    = {r_p1, 16'h0000} + {32'd0, r_p0[63:16]};
    assign w_term    = (w_psum > 80'(ACC_MAX)) ? ACC_MAX : w_psum[ACC_WIDTH-1:0];
    assign w_acc_sum = {1'b0, r_sum} + {1'b0, r_term};
    assign w_sum64   = 64'(r_sum);
    assign w_dens    = (w_sum64 > 64'(OUT_MAX)) ? OUT_MAX : w_sum64[47:0];
    assign w_rest48  = {16'd0, i_cfg.rest_density};
    assign w_ge      = w_dens >= w_rest48;
    assign w_mag     = w_ge ? (w_dens - w_rest48) : (w_rest48 - w_dens);
    assign w_cap     = r_neg ? PRS_NEG_MAG : PRS_POS_MAX;
    assign w_mag_sat = (w_psum > 80'(w_cap)) ? w_cap : w_psum[47:0];
    assign w_prs     = r_neg ? (48'd0 - w_mag_sat) : w_mag_sat;

    assign o_empty    = !r_out_valid;
    assign o_density  = r_density;
    assign o_pressure = r_pressure;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        w_mul_en    = 1'b0;
        w_load      = 1'b0;
        w_a0        = r_d;
        w_a1        = '0;
        w_b         = r_d;
        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == OP_LOAD) begin
                        n_sum = '0;
                    end
                    if (i_q_item.op == OP_NEIGHBOR && i_q_item.hit) begin
                        n_state = ST_D2;
                    end else if (i_q_item.last) begin
                        n_state = ST_PD;
                    end
                end
            end
            ST_D2: begin
                w_mul_en = 1'b1;
                n_state  = ST_D3;
            end
            ST_D3: begin
                w_mul_en = 1'b1;
                w_a0     = r_p0[47:16];
                w_a1     = {16'd0, r_p0[63:48]};
                n_state  = ST_D3S;
            end
            ST_D3S: begin
                n_state = ST_T;
            end
            ST_T: begin
                w_mul_en = 1'b1;
                w_a0     = r_x[31:0];
                w_a1     = r_x[63:32];
                w_b      = i_cfg.density_scale;
                n_state  = ST_TERM;
            end
            ST_TERM: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sum   = w_acc_sum[ACC_WIDTH] ? ACC_MAX : w_acc_sum[ACC_WIDTH-1:0];
                n_state = r_last ? ST_PD : ST_IDLE;
            end
            ST_PD: begin
                n_state = ST_PM;
            end
            ST_PM: begin
                w_mul_en = 1'b1;
                w_a0     = r_x[31:0];
                w_a1     = {16'd0, r_x[47:32]};
                w_b      = i_cfg.stiffness;
                n_state  = ST_PS;
            end
            ST_PS: begin
                if (!r_out_valid || i_pop) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_d    <= i_q_item.d;
            r_last <= i_q_item.last;
        end
        if (w_mul_en) begin
            r_p0 <= w_a0 * w_b;
            r_p1 <= w_a1 * w_b;
        end
        if (r_state == ST_D3S) begin
            r_x <= w_psum[63:0];
        end
        if (r_state == ST_TERM) begin
            r_term <= w_term;
        end
        if (r_state == ST_PD) begin
            r_x   <= {16'd0, w_mag};
            r_neg <= !w_ge;
        end
        if (w_load) begin
            r_density  <= w_dens;
            r_pressure <= w_prs;
        end
    end

endmodule

>>> hw/rtl/sph_density_pressure.sv
// SPH poly6 density and pressure for one target particle. A load item sets the target
// and clears the sum; each neighbor item adds density_scale*(h2-r2)^3 when inside the
// radius; an item with last set yields one density/pressure result. The front end takes
// one item per cycle while the queue is not full, through a four-stage distance pipeline
// into a four-entry queue. The back end drains that queue through a shared pair of 32x32
// multipliers: loads and out-of-radius neighbors are popped in IDLE, an in-radius one
// steps through D2, D3, D3S, T, TERM and ACC, and a result adds PD, PM and PS; the next
// item is popped back in IDLE, so this sequence sets the sustained rate. A result waits in
// an output register while the front end keeps taking items; the next result holds in PS.
// Depends on sph_dp_pkg, sph_dp_front, sph_dp_queue and sph_dp_back.
module sph_density_pressure import sph_dp_pkg::*; #(
    parameter int unsigned ACC_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_op,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic                  i_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [47:0]           o_density,
    output logic signed [47:0]    o_pressure,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]           i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_q_push;
    logic        w_q_full;
    logic        w_q_pop;
    logic        w_q_empty;
    t_front_item w_front_item;
    t_front_item w_head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_sq     <= RADIUS_SQ_RST;
            r_cfg.density_scale <= DENSITY_SCALE_RST;
            r_cfg.rest_density  <= REST_DENSITY_RST;
            r_cfg.stiffness     <= STIFFNESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RADIUS_SQ:     r_cfg.radius_sq     <= i_cfg_data;
                CFG_DENSITY_SCALE: r_cfg.density_scale <= i_cfg_data;
                CFG_REST_DENSITY:  r_cfg.rest_density  <= i_cfg_data;
                CFG_STIFFNESS:     r_cfg.stiffness     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sph_dp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_last      (i_last),
        .i_radius_sq (r_cfg.radius_sq),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_item    (w_front_item)
    );

    sph_dp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_head_item)
    );

    sph_dp_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .i_q_item   (w_head_item),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_density  (o_density),
        .o_pressure (o_pressure)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("queue push while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue pop while empty");

    a_stall_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_q_full)
        else $error("front end stalled with room in the queue");

endmodule

>>> tb/sv/sph_density_pressure_chk.sv
// Checker for sph_density_pressure: follows the item, result and register ports,
// predicts density and pressure per target and compares every result beat.
// Depends on sph_dp_pkg.
module sph_density_pressure_chk import sph_dp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_op,
    input  logic [31:0]           i_pos_x,
    input  logic [31:0]           i_pos_y,
    input  logic [31:0]           i_pos_z,
    input  logic                  i_last,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [47:0]           i_density,
    input  logic [47:0]           i_pressure,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]           i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] ACC_MAX = OUT_MAX;

    typedef struct packed {
        logic [47:0] density;
        logic [47:0] pressure;
    } t_dens_prs;

    t_cfg        cfg;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] tgt_z;
    logic [47:0] dens_sum;
    t_dens_prs   dens_prs_q[$];
    int          mismatches = 0;
    int          pending = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending;

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] axis_dist(input logic [31:0] n, input logic [31:0] t);
        logic signed [32:0] diff;
        diff = $signed({n[31], n}) - $signed({t[31], t});
        return (diff < 0) ? 32'(-diff) : 32'(diff);
    endfunction

    function automatic logic [47:0] poly6_term(input logic [31:0] nx, input logic [31:0] ny,
                                               input logic [31:0] nz);
        logic [31:0]  ax;
        logic [31:0]  ay;
        logic [31:0]  az;
        logic [31:0]  d;
        logic [67:0]  r2;
        logic [63:0]  d2;
        logic [63:0]  d3;
        logic [127:0] wide;
        ax = axis_dist(nx, tgt_x);
        ay = axis_dist(ny, tgt_y);
        az = axis_dist(nz, tgt_z);
        r2 = (68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az)) >> 16;
        if (r2 >= 68'(cfg.radius_sq)) return '0;
        d    = cfg.radius_sq - r2[31:0];
        d2   = (64'(d) * 64'(d)) >> 16;
        wide = (128'(d2) * 128'(d)) >> 16;
        d3   = wide[63:0];
        wide = (128'(d3) * 128'(cfg.density_scale)) >> 16;
        return (wide > 128'(ACC_MAX)) ? ACC_MAX : wide[47:0];
    endfunction

    function automatic logic [47:0] pressure_of(input logic [47:0] dens);
        logic [47:0] rest;
        logic [95:0] mag;
        rest = 48'(cfg.rest_density);
        if (dens >= rest) begin
            mag = (96'(dens - rest) * 96'(cfg.stiffness)) >> 16;
            return (mag > 96'(PRS_POS_MAX)) ? PRS_POS_MAX : mag[47:0];
        end
        mag = (96'(rest - dens) * 96'(cfg.stiffness)) >> 16;
        if (mag > 96'(PRS_NEG_MAG)) mag = 96'(PRS_NEG_MAG);
        return -mag[47:0];
    endfunction

    always @(posedge i_clk) begin
        t_dens_prs   want;
        logic [47:0] term;
        logic [48:0] sum;
        if (!i_rst_n) begin
            cfg.radius_sq     = RADIUS_SQ_RST;
            cfg.density_scale = DENSITY_SCALE_RST;
            cfg.rest_density  = REST_DENSITY_RST;
            cfg.stiffness     = STIFFNESS_RST;
            tgt_x    = '0;
            tgt_y    = '0;
            tgt_z    = '0;
            dens_sum = '0;
            dens_prs_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (dens_prs_q.size() == 0) begin
                    report("unexpected result beat, density", i_density, '0);
                end else begin
                    want = dens_prs_q.pop_front();
                    if (i_density !== want.density) report("density", i_density, want.density);
                    if (i_pressure !== want.pressure)
                        report("pressure", i_pressure, want.pressure);
                end
            end
            if (i_push && !i_full) begin
                if (i_op == OP_LOAD) begin
                    tgt_x    = i_pos_x;
                    tgt_y    = i_pos_y;
                    tgt_z    = i_pos_z;
                    dens_sum = '0;
                end else begin
                    term     = poly6_term(i_pos_x, i_pos_y, i_pos_z);
                    sum      = {1'b0, dens_sum} + {1'b0, term};
                    dens_sum = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[47:0];
                end
                if (i_last) begin
                    want.density  = dens_sum;
                    want.pressure = pressure_of(dens_sum);
                    dens_prs_q.insert(dens_prs_q.size(), want);
                    dens_sum = '0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_RADIUS_SQ:     cfg.radius_sq     = i_cfg_data;
                    CFG_DENSITY_SCALE: cfg.density_scale = i_cfg_data;
                    CFG_REST_DENSITY:  cfg.rest_density  = i_cfg_data;
                    CFG_STIFFNESS:     cfg.stiffness     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending <= dens_prs_q.size();
    end

endmodule

>>> tb/sv/sph_density_pressure_tb.sv
// Top of the sph_density_pressure bench: clock, reset, item stimulus with bursts,
// result stalls and register phases; verdict from the checker's mismatch and pending counts.
// Depends on sph_dp_pkg, sph_density_pressure and sph_density_pressure_chk.
module sph_density_pressure_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sph_dp_pkg::*;

    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 55;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_op = OP_LOAD;
    logic signed [31:0]    i_pos_x = '0;
    logic signed [31:0]    i_pos_y = '0;
    logic signed [31:0]    i_pos_z = '0;
    logic                  i_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [47:0]           o_density;
    logic signed [47:0]    o_pressure;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = CFG_RADIUS_SQ;
    logic [31:0]           i_cfg_data = '0;

    int          errors;
    int          pending;
    int          quiet = 0;
    int          sent = 0;
    int          burst_left = 0;
    bit          idle_on = 1'b1;
    logic [15:0] pop_pattern = 16'hFFFF;
    logic [3:0]  stall_idx = '0;
    logic [31:0] radius = RADIUS_SQ_RST;
    logic [31:0] cur_x = '0;
    logic [31:0] cur_y = '0;
    logic [31:0] cur_z = '0;

    sph_density_pressure i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_last     (i_last),
        .empty      (empty),
        .pop        (pop),
        .o_density  (o_density),
        .o_pressure (o_pressure),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    sph_density_pressure_chk chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_op       (i_op),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_last     (i_last),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_density  (o_density),
        .i_pressure (o_pressure),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pop       <= pop_pattern[stall_idx];
        stall_idx <= stall_idx + 4'd1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("sph_density_pressure_tb: errors");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = idle_on ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (op == OP_LOAD) begin
            cur_x = x;
            cur_y = y;
            cur_z = z;
        end
        push    <= 1'b1;
        i_op    <= op;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_last  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
    endtask

    // hold the sender until every result has been seen, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] radius_sq, input logic [31:0] scale,
                                input logic [31:0] rest, input logic [31:0] gas);
        radius = radius_sq;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_RADIUS_SQ;
        i_cfg_data <= radius_sq;
        @(posedge i_clk);
        i_cfg_addr <= CFG_DENSITY_SCALE;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_addr <= CFG_REST_DENSITY;
        i_cfg_data <= rest;
        @(posedge i_clk);
        i_cfg_addr <= CFG_STIFFNESS;
        i_cfg_data <= gas;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one target: optional load, then neighbors mostly inside the radius
    task automatic send_group(input int unsigned reach);
        int unsigned n;
        int          k;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        n = $urandom_range(0, 6);
        if ($urandom_range(0, 4) != 0)
            send_item(OP_LOAD, $urandom, $urandom, $urandom, n == 0);
        for (k = 0; k < int'(n); k++) begin
            case ($urandom_range(0, 7))
                0: begin
                    x = cur_x;
                    y = cur_y;
                    z = cur_z;
                end
                1: begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                default: begin
                    x = cur_x + ($urandom_range(0, 2 * reach) - reach);
                    y = cur_y + ($urandom_range(0, 2 * reach) - reach);
                    z = cur_z + ($urandom_range(0, 2 * reach) - reach);
                end
            endcase
            send_item(OP_NEIGHBOR, x, y, z, k == int'(n) - 1);
        end
    endtask

    initial begin
        int          phase;
        int          stop_at;
        int unsigned reach;
        logic [31:0] rnd_radius;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // neighbors before any load, measured from the origin
        send_item(OP_NEIGHBOR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // continue on the kept target after a result, target itself included
        send_item(OP_NEIGHBOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'h8000_4000, 32'h7FFF_C000, 32'h8000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_item(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(OP_NEIGHBOR, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_NEIGHBOR, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 1'b0);
        send_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_NEIGHBOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);

        for (phase = 1; phase <= PHASES; phase++) begin
            drain();
            case ($urandom_range(0, 2))
                0:       rnd_radius = $urandom;
                1:       rnd_radius = $urandom_range(1, 32'h0010_0000);
                default: rnd_radius = 32'h1 << $urandom_range(0, 31);
            endcase
            case (phase)
                1:       write_config('0, '0, '0, '0);
                2:       write_config('1, '1, '1, '1);
                3:       write_config('1, '1, '0, '1);
                4:       write_config(32'h0004_0000, '1, '1, '1);
                default: write_config(rnd_radius, $urandom, $urandom, $urandom);
            endcase
            idle_on = (phase % 3) != 0;
            pop_pattern <= (phase % 4 == 2) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            reach   = int'($sqrt(real'(radius)) * 150.0);
            stop_at = sent + PHASE_ITEMS;
            while (sent < stop_at) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              $urandom_range(0, 3) == 0);
                else
                    send_group(reach);
            end
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("sph_density_pressure_tb: clean");
        else
            $display("sph_density_pressure_tb: errors");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sph_dp_pkg.sv
hw/rtl/sph_dp_front.sv
hw/rtl/sph_dp_queue.sv
hw/rtl/sph_dp_back.sv
hw/rtl/sph_density_pressure.sv
tb/sv/sph_density_pressure_chk.sv
tb/sv/sph_density_pressure_tb.sv
